>>> hdl/lwbc_pkg.sv
// ----------------------------------------------------------------------------
// lwbc_pkg: shared definitions of the block cache directory
// Field widths, request and result codes, register indexes and the
// command and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package lwbc_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_SLOTS       = 64;
    localparam int DEF_BLOCK_BYTES = 4096;
    localparam int DEF_KEY_BITS    = 16;
    localparam int MIN_ACTIVE      = 16;

    // Port field widths
    localparam int TYPE_W   = 3;
    localparam int KEY_IN_W = 16;
    localparam int BLK_W    = 20;
    localparam int SLOT_W   = 6;
    localparam int LEN_W    = 13;
    localparam int AGE_W    = 32;
    localparam int KIND_W   = 3;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_READ   = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_FULL   = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_PART   = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_FILL   = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_WBDONE = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_FLUSH  = 3'd5;
    localparam logic [TYPE_W-1:0] REQ_INVAL  = 3'd6;

    // Result codes
    localparam logic [KIND_W-1:0] KIND_HIT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FILL   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WB     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BYPASS = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_REJECT = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } lwbc_state_t;

    typedef struct packed {
        logic accept;    // item taken this cycle
        logic data_vld;  // scan read data present
        logic finish;    // scan complete, resolve the item
    } lwbc_cmd_t;

    typedef struct packed {
        logic scan;      // presented item needs a directory scan
    } lwbc_status_t;

endpackage

>>> hdl/lru_writeback_block_cache_directory.sv
// ----------------------------------------------------------------------------
// lru_writeback_block_cache_directory: write-back block cache directory
// Fully associative directory with LRU victim choice and write-back commands.
// ----------------------------------------------------------------------------
// Usage
//   Present an item on the request ports with start high; it is taken at the
//   clock edge where start is high and busy is low. Every result is shown for
//   exactly one cycle with strobe high; last marks the final result of the
//   item. The receiver cannot hold results off, so nothing ever stalls here.
//   Completions (fill done, write-back done), unknown codes and any read or
//   write while cache_enable is zero resolve at once: one result on the cycle
//   after the transfer, and a new item may follow straight away.
//   Reads, full and partial writes, flush and invalidate walk the live slots
//   one per cycle through the key/block, length and age memories; there are
//   16..SLOTS live slots. Such an item holds busy through the scan, drain and
//   finish states, its final result appearing on the cycle busy drops; flush
//   and invalidate emit their earlier write-back results while busy is still
//   high.
//   Configuration: cfg_we, cfg_addr, cfg_wdata write one register per cycle;
//   write only while idle. Index 0 is cache_enable, index 1 active_slots.
//   Reset clears valid and dirty, sets the age clock to one, enables the
//   cache with all slots live and needs no clearing pass.
// ----------------------------------------------------------------------------
module lru_writeback_block_cache_directory #(
    parameter int SLOTS       = lwbc_pkg::DEF_SLOTS,
    parameter int BLOCK_BYTES = lwbc_pkg::DEF_BLOCK_BYTES,
    parameter int KEY_BITS    = lwbc_pkg::DEF_KEY_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [lwbc_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [lwbc_pkg::CFG_W-1:0]       cfg_wdata,
    // request
    input  logic                             start,
    output logic                             busy,
    input  logic [lwbc_pkg::TYPE_W-1:0]      req_type,
    input  logic [lwbc_pkg::KEY_IN_W-1:0]    file_key,
    input  logic [lwbc_pkg::BLK_W-1:0]       block_index,
    input  logic [lwbc_pkg::SLOT_W-1:0]      slot_index,
    input  logic [lwbc_pkg::LEN_W-1:0]       fill_length,
    input  logic                             writeback_ok,
    input  logic                             invalidate_all,
    // results
    output logic                             strobe,
    output logic [lwbc_pkg::KIND_W-1:0]      result_kind,
    output logic [lwbc_pkg::SLOT_W-1:0]      result_slot,
    output logic [lwbc_pkg::KEY_IN_W-1:0]    victim_key,
    output logic [lwbc_pkg::BLK_W-1:0]       victim_block,
    output logic [lwbc_pkg::LEN_W-1:0]       victim_length,
    output logic                             last
);

    lwbc_pkg::lwbc_cmd_t    cmd;
    lwbc_pkg::lwbc_status_t st;
    logic [$clog2(SLOTS+1)-1:0] live_n;
    logic [$clog2(SLOTS)-1:0]   scan_addr;
    logic [$clog2(SLOTS)-1:0]   data_idx;

    // Sequencer: accept, scan walk, resolve
    lwbc_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .st        (st),
        .live_n    (live_n),
        .cmd       (cmd),
        .scan_addr (scan_addr),
        .data_idx  (data_idx),
        .busy      (busy)
    );

    // Directory storage and result stage
    lwbc_dp #(
        .SLOTS       (SLOTS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .req_type       (req_type),
        .file_key       (file_key),
        .block_index    (block_index),
        .slot_index     (slot_index),
        .fill_length    (fill_length),
        .writeback_ok   (writeback_ok),
        .invalidate_all (invalidate_all),
        .cmd            (cmd),
        .scan_addr      (scan_addr),
        .data_idx       (data_idx),
        .st             (st),
        .live_n         (live_n),
        .strobe         (strobe),
        .result_kind    (result_kind),
        .result_slot    (result_slot),
        .victim_key     (victim_key),
        .victim_block   (victim_block),
        .victim_length  (victim_length),
        .last           (last)
    );

endmodule

>>> hdl/lwbc_ram.sv
// ----------------------------------------------------------------------------
// lwbc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lwbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/lwbc_ctrl.sv
// ----------------------------------------------------------------------------
// lwbc_ctrl: sequencer of the directory
// Accepts items, walks the scan address over the live slots and tells the
// datapath when read data is present and when to resolve the item.
// ----------------------------------------------------------------------------
module lwbc_ctrl #(
    parameter int SLOTS = lwbc_pkg::DEF_SLOTS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  lwbc_pkg::lwbc_status_t    st,
    input  logic [$clog2(SLOTS+1)-1:0] live_n,
    output lwbc_pkg::lwbc_cmd_t       cmd,
    output logic [$clog2(SLOTS)-1:0]   scan_addr,
    output logic [$clog2(SLOTS)-1:0]   data_idx,
    output logic                       busy
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    lwbc_pkg::lwbc_state_t state_reg, state_next;
    logic [CNT_W-1:0] addr_reg, addr_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] data_idx_reg, data_idx_next;

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        cmd           = '0;
        unique case (state_reg)
            lwbc_pkg::ST_IDLE:
            begin
                cmd.accept = start;
                if (start && st.scan)
                begin
                    state_next = lwbc_pkg::ST_SCAN;
                    addr_next  = '0;
                end
            end
            lwbc_pkg::ST_SCAN:
            begin
                addr_next = CNT_W'(addr_reg + 1'b1);
                if (addr_reg == CNT_W'(live_n - 1'b1))
                begin
                    state_next = lwbc_pkg::ST_DRAIN;
                end
            end
            lwbc_pkg::ST_DRAIN:
            begin
                state_next = lwbc_pkg::ST_FINISH;
            end
            lwbc_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = lwbc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lwbc_pkg::ST_IDLE;
            end
        endcase
        cmd.data_vld  = rd_vld_reg;
        rd_vld_next   = (state_reg == lwbc_pkg::ST_SCAN);
        data_idx_next = addr_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lwbc_pkg::ST_IDLE;
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_idx_reg <= data_idx_next;
    end

    assign scan_addr = addr_reg[IDX_W-1:0];
    assign data_idx  = data_idx_reg;
    assign busy      = (state_reg != lwbc_pkg::ST_IDLE);

endmodule

>>> hdl/lwbc_dp.sv
// ----------------------------------------------------------------------------
// lwbc_dp: directory datapath
// Slot flags, key/block, length and age memories, scan accumulators,
// pending write-back holder and the registered result stage.
// ----------------------------------------------------------------------------
module lwbc_dp #(
    parameter int SLOTS       = lwbc_pkg::DEF_SLOTS,
    parameter int BLOCK_BYTES = lwbc_pkg::DEF_BLOCK_BYTES,
    parameter int KEY_BITS    = lwbc_pkg::DEF_KEY_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lwbc_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [lwbc_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic [lwbc_pkg::TYPE_W-1:0]          req_type,
    input  logic [lwbc_pkg::KEY_IN_W-1:0]        file_key,
    input  logic [lwbc_pkg::BLK_W-1:0]           block_index,
    input  logic [lwbc_pkg::SLOT_W-1:0]          slot_index,
    input  logic [lwbc_pkg::LEN_W-1:0]           fill_length,
    input  logic                                 writeback_ok,
    input  logic                                 invalidate_all,
    input  lwbc_pkg::lwbc_cmd_t                  cmd,
    input  logic [$clog2(SLOTS)-1:0]             scan_addr,
    input  logic [$clog2(SLOTS)-1:0]             data_idx,
    output lwbc_pkg::lwbc_status_t               st,
    output logic [$clog2(SLOTS+1)-1:0]           live_n,
    output logic                                 strobe,
    output logic [lwbc_pkg::KIND_W-1:0]          result_kind,
    output logic [lwbc_pkg::SLOT_W-1:0]          result_slot,
    output logic [lwbc_pkg::KEY_IN_W-1:0]        victim_key,
    output logic [lwbc_pkg::BLK_W-1:0]           victim_block,
    output logic [lwbc_pkg::LEN_W-1:0]           victim_length,
    output logic                                 last
);

    localparam int KW    = (KEY_BITS < lwbc_pkg::KEY_IN_W) ? KEY_BITS : lwbc_pkg::KEY_IN_W;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int BW    = lwbc_pkg::BLK_W;
    localparam int LW    = lwbc_pkg::LEN_W;
    localparam int AW    = lwbc_pkg::AGE_W;
    localparam int KBW   = KW + BW;
    localparam logic [LW-1:0] LEN_FULL = LW'(BLOCK_BYTES);
    localparam logic [16:0]   BB_MAX   = 17'(BLOCK_BYTES);
    localparam logic [lwbc_pkg::SLOT_W:0] SLOT_LIM = (lwbc_pkg::SLOT_W + 1)'(SLOTS);

    // Configuration
    logic                       enable_reg;
    logic [lwbc_pkg::CFG_W-1:0] active_reg;
    logic [CNT_W-1:0]           live_cnt;

    // Slot flags and counters
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [SLOTS-1:0] dirty_reg, dirty_next;
    logic [AW-1:0]    age_clock_reg, age_clock_next;

    // Latched request
    logic [lwbc_pkg::TYPE_W-1:0] req_reg, req_next;
    logic [KW-1:0]    key_reg, key_next;
    logic [BW-1:0]    blk_reg, blk_next;
    logic             all_reg, all_next;
    logic [CNT_W-1:0] live_reg, live_next;

    // Scan accumulators
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [LW-1:0]    hit_len_reg, hit_len_next;
    logic             inv_found_reg, inv_found_next;
    logic [IDX_W-1:0] inv_idx_reg, inv_idx_next;
    logic [IDX_W-1:0] min_idx_reg, min_idx_next;
    logic [AW-1:0]    min_age_reg, min_age_next;
    logic [KW-1:0]    min_key_reg, min_key_next;
    logic [BW-1:0]    min_blk_reg, min_blk_next;
    logic [LW-1:0]    min_len_reg, min_len_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [KW-1:0]    pend_key_reg, pend_key_next;
    logic [BW-1:0]    pend_blk_reg, pend_blk_next;
    logic [LW-1:0]    pend_len_reg, pend_len_next;

    // Result stage
    logic                        strobe_reg, strobe_next;
    logic [lwbc_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [lwbc_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [lwbc_pkg::KEY_IN_W-1:0] vkey_reg, vkey_next;
    logic [BW-1:0]               vblk_reg, vblk_next;
    logic [LW-1:0]               vlen_reg, vlen_next;
    logic                        last_reg, last_next;

    // Memory ports
    logic             kb_we, len_we, age_we;
    logic [IDX_W-1:0] kb_waddr, len_waddr, age_waddr;
    logic [KBW-1:0]   kb_wdata, kb_rdata;
    logic [LW-1:0]    len_wdata, rd_len;
    logic [AW-1:0]    age_wdata, rd_age;
    logic [KW-1:0]    rd_key;
    logic [BW-1:0]    rd_blk;

    // Working values
    logic             e_load, e_last;
    logic [lwbc_pkg::KIND_W-1:0] e_kind;
    logic [IDX_W-1:0] e_slot;
    logic [KW-1:0]    e_key;
    logic [BW-1:0]    e_blk;
    logic [LW-1:0]    e_len;
    logic             lookup_op, sidx_ok, flen_ok, d_v, d_d, key_eq, blk_eq, inv_match;
    logic [IDX_W-1:0] sidx, victim;
    logic             vict_dirty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            active_reg <= lwbc_pkg::ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                lwbc_pkg::CFG_ENABLE: enable_reg <= cfg_wdata[0];
                lwbc_pkg::CFG_ACTIVE: active_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp the live slot count to MIN_ACTIVE..SLOTS
    always_comb
    begin
        if (active_reg < lwbc_pkg::CFG_W'(lwbc_pkg::MIN_ACTIVE))
        begin
            live_cnt = CNT_W'(lwbc_pkg::MIN_ACTIVE);
        end
        else if (active_reg > lwbc_pkg::CFG_W'(SLOTS))
        begin
            live_cnt = CNT_W'(SLOTS);
        end
        else
        begin
            live_cnt = CNT_W'(active_reg);
        end
    end

    assign lookup_op = (req_type == lwbc_pkg::REQ_READ) || (req_type == lwbc_pkg::REQ_FULL)
                    || (req_type == lwbc_pkg::REQ_PART);
    assign st.scan   = (lookup_op && enable_reg) || (req_type == lwbc_pkg::REQ_FLUSH)
                    || (req_type == lwbc_pkg::REQ_INVAL);
    assign live_n    = live_reg;

    assign sidx    = slot_index[IDX_W-1:0];
    assign sidx_ok = {1'b0, slot_index} < SLOT_LIM;
    assign flen_ok = (fill_length != '0) && ({4'd0, fill_length} <= BB_MAX);

    assign rd_key = kb_rdata[KBW-1:BW];
    assign rd_blk = kb_rdata[BW-1:0];

    assign d_v       = valid_reg[data_idx];
    assign d_d       = dirty_reg[data_idx];
    assign key_eq    = (rd_key == key_reg);
    assign blk_eq    = (rd_blk == blk_reg);
    assign inv_match = d_v && (all_reg || key_eq);

    assign victim     = inv_found_reg ? inv_idx_reg : min_idx_reg;
    assign vict_dirty = !inv_found_reg && dirty_reg[min_idx_reg];

    always_comb
    begin
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        age_clock_next = age_clock_reg;
        req_next       = req_reg;
        key_next       = key_reg;
        blk_next       = blk_reg;
        all_next       = all_reg;
        live_next      = live_reg;
        hit_found_next = hit_found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_len_next   = hit_len_reg;
        inv_found_next = inv_found_reg;
        inv_idx_next   = inv_idx_reg;
        min_idx_next   = min_idx_reg;
        min_age_next   = min_age_reg;
        min_key_next   = min_key_reg;
        min_blk_next   = min_blk_reg;
        min_len_next   = min_len_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        pend_key_next  = pend_key_reg;
        pend_blk_next  = pend_blk_reg;
        pend_len_next  = pend_len_reg;
        kb_we     = 1'b0;
        kb_waddr  = victim;
        kb_wdata  = {key_reg, blk_reg};
        len_we    = 1'b0;
        len_waddr = victim;
        len_wdata = '0;
        age_we    = 1'b0;
        age_waddr = victim;
        age_wdata = '0;
        e_load = 1'b0;
        e_last = 1'b1;
        e_kind = lwbc_pkg::KIND_DONE;
        e_slot = '0;
        e_key  = '0;
        e_blk  = '0;
        e_len  = '0;

        if (cmd.accept)
        begin
            req_next       = req_type;
            key_next       = file_key[KW-1:0];
            blk_next       = block_index;
            all_next       = invalidate_all;
            live_next      = live_cnt;
            hit_found_next = 1'b0;
            inv_found_next = 1'b0;
            pend_vld_next  = 1'b0;
            if (lookup_op && !enable_reg)
            begin
                e_load = 1'b1;
                e_kind = lwbc_pkg::KIND_BYPASS;
            end
            else if (st.scan)
            begin
                // result comes after the scan
            end
            else if (req_type == lwbc_pkg::REQ_FILL)
            begin
                e_load = 1'b1;
                if (sidx_ok && flen_ok && !valid_reg[sidx])
                begin
                    valid_next[sidx] = 1'b1;
                    dirty_next[sidx] = 1'b0;
                    len_we         = 1'b1;
                    len_waddr      = sidx;
                    len_wdata      = fill_length;
                    age_clock_next = age_clock_reg + 1'b1;
                    age_we         = 1'b1;
                    age_waddr      = sidx;
                    age_wdata      = age_clock_next;
                    e_kind = lwbc_pkg::KIND_DONE;
                    e_slot = sidx;
                end
                else
                begin
                    e_kind = lwbc_pkg::KIND_REJECT;
                end
            end
            else if (req_type == lwbc_pkg::REQ_WBDONE)
            begin
                e_load = 1'b1;
                if (sidx_ok && valid_reg[sidx] && dirty_reg[sidx] && writeback_ok)
                begin
                    dirty_next[sidx] = 1'b0;
                    e_kind = lwbc_pkg::KIND_DONE;
                    e_slot = sidx;
                end
                else
                begin
                    e_kind = lwbc_pkg::KIND_REJECT;
                end
            end
            else
            begin
                e_load = 1'b1;
                e_kind = lwbc_pkg::KIND_REJECT;
            end
        end

        if (cmd.data_vld)
        begin
            if ((req_reg == lwbc_pkg::REQ_FLUSH) || (req_reg == lwbc_pkg::REQ_INVAL))
            begin
                if ((req_reg == lwbc_pkg::REQ_INVAL) && inv_match && !d_d)
                begin
                    valid_next[data_idx] = 1'b0;
                end
                if (d_v && d_d && ((req_reg == lwbc_pkg::REQ_FLUSH) || inv_match))
                begin
                    // release the held write-back, hold the new one
                    if (pend_vld_reg)
                    begin
                        e_load = 1'b1;
                        e_last = 1'b0;
                        e_kind = lwbc_pkg::KIND_WB;
                        e_slot = pend_idx_reg;
                        e_key  = pend_key_reg;
                        e_blk  = pend_blk_reg;
                        e_len  = pend_len_reg;
                    end
                    pend_vld_next = 1'b1;
                    pend_idx_next = data_idx;
                    pend_key_next = rd_key;
                    pend_blk_next = rd_blk;
                    pend_len_next = rd_len;
                end
            end
            else
            begin
                if (!hit_found_reg && d_v && key_eq && blk_eq)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = data_idx;
                    hit_len_next   = rd_len;
                end
                if (!inv_found_reg && !d_v)
                begin
                    inv_found_next = 1'b1;
                    inv_idx_next   = data_idx;
                end
                if ((data_idx == '0) || (rd_age < min_age_reg))
                begin
                    min_idx_next = data_idx;
                    min_age_next = rd_age;
                    min_key_next = rd_key;
                    min_blk_next = rd_blk;
                    min_len_next = rd_len;
                end
            end
        end

        if (cmd.finish)
        begin
            e_load = 1'b1;
            case (req_reg) inside
                lwbc_pkg::REQ_READ, lwbc_pkg::REQ_FULL:
                begin
                    if (hit_found_reg)
                    begin
                        age_clock_next = age_clock_reg + 1'b1;
                        age_we    = 1'b1;
                        age_waddr = hit_idx_reg;
                        age_wdata = age_clock_next;
                        if (req_reg == lwbc_pkg::REQ_FULL)
                        begin
                            dirty_next[hit_idx_reg] = 1'b1;
                            len_we    = 1'b1;
                            len_waddr = hit_idx_reg;
                            len_wdata = LEN_FULL;
                        end
                        e_kind = lwbc_pkg::KIND_HIT;
                        e_slot = hit_idx_reg;
                    end
                    else if (vict_dirty)
                    begin
                        e_kind = lwbc_pkg::KIND_WB;
                        e_slot = min_idx_reg;
                        e_key  = min_key_reg;
                        e_blk  = min_blk_reg;
                        e_len  = min_len_reg;
                    end
                    else
                    begin
                        kb_we  = 1'b1;
                        len_we = 1'b1;
                        age_we = 1'b1;
                        e_slot = victim;
                        if (req_reg == lwbc_pkg::REQ_FULL)
                        begin
                            valid_next[victim] = 1'b1;
                            dirty_next[victim] = 1'b1;
                            len_wdata      = LEN_FULL;
                            age_clock_next = age_clock_reg + 1'b1;
                            age_wdata      = age_clock_next;
                            e_kind = lwbc_pkg::KIND_DONE;
                        end
                        else
                        begin
                            valid_next[victim] = 1'b0;
                            dirty_next[victim] = 1'b0;
                            e_kind = lwbc_pkg::KIND_FILL;
                        end
                    end
                end
                lwbc_pkg::REQ_PART:
                begin
                    if (hit_found_reg && dirty_reg[hit_idx_reg])
                    begin
                        e_kind = lwbc_pkg::KIND_WB;
                        e_slot = hit_idx_reg;
                        e_key  = key_reg;
                        e_blk  = blk_reg;
                        e_len  = hit_len_reg;
                    end
                    else
                    begin
                        if (hit_found_reg)
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                        end
                        e_kind = lwbc_pkg::KIND_BYPASS;
                    end
                end
                lwbc_pkg::REQ_FLUSH, lwbc_pkg::REQ_INVAL:
                begin
                    if (pend_vld_reg)
                    begin
                        pend_vld_next = 1'b0;
                        e_kind = lwbc_pkg::KIND_WB;
                        e_slot = pend_idx_reg;
                        e_key  = pend_key_reg;
                        e_blk  = pend_blk_reg;
                        e_len  = pend_len_reg;
                    end
                    else
                    begin
                        e_kind = lwbc_pkg::KIND_DONE;
                    end
                end
                default:
                begin
                    e_kind = lwbc_pkg::KIND_REJECT;
                end
            endcase
        end

        strobe_next = e_load;
        kind_next   = e_load ? e_kind : kind_reg;
        slot_next   = e_load ? lwbc_pkg::SLOT_W'(e_slot) : slot_reg;
        vkey_next   = e_load ? lwbc_pkg::KEY_IN_W'(e_key) : vkey_reg;
        vblk_next   = e_load ? e_blk : vblk_reg;
        vlen_next   = e_load ? e_len : vlen_reg;
        last_next   = e_load ? e_last : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            dirty_reg     <= '0;
            age_clock_reg <= AW'(1);
            hit_found_reg <= 1'b0;
            inv_found_reg <= 1'b0;
            pend_vld_reg  <= 1'b0;
            strobe_reg    <= 1'b0;
            req_reg       <= lwbc_pkg::REQ_READ;
            live_reg      <= CNT_W'(SLOTS);
        end
        else
        begin
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            age_clock_reg <= age_clock_next;
            hit_found_reg <= hit_found_next;
            inv_found_reg <= inv_found_next;
            pend_vld_reg  <= pend_vld_next;
            strobe_reg    <= strobe_next;
            req_reg       <= req_next;
            live_reg      <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        blk_reg      <= blk_next;
        all_reg      <= all_next;
        hit_idx_reg  <= hit_idx_next;
        hit_len_reg  <= hit_len_next;
        inv_idx_reg  <= inv_idx_next;
        min_idx_reg  <= min_idx_next;
        min_age_reg  <= min_age_next;
        min_key_reg  <= min_key_next;
        min_blk_reg  <= min_blk_next;
        min_len_reg  <= min_len_next;
        pend_idx_reg <= pend_idx_next;
        pend_key_reg <= pend_key_next;
        pend_blk_reg <= pend_blk_next;
        pend_len_reg <= pend_len_next;
        kind_reg     <= kind_next;
        slot_reg     <= slot_next;
        vkey_reg     <= vkey_next;
        vblk_reg     <= vblk_next;
        vlen_reg     <= vlen_next;
        last_reg     <= last_next;
    end

    lwbc_ram #(.WIDTH(KBW), .DEPTH(SLOTS)) u_kb_ram (
        .clk   (clk),
        .we    (kb_we),
        .waddr (kb_waddr),
        .wdata (kb_wdata),
        .raddr (scan_addr),
        .rdata (kb_rdata)
    );

    lwbc_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (scan_addr),
        .rdata (rd_len)
    );

    lwbc_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_age_ram (
        .clk   (clk),
        .we    (age_we),
        .waddr (age_waddr),
        .wdata (age_wdata),
        .raddr (scan_addr),
        .rdata (rd_age)
    );

    assign strobe        = strobe_reg;
    assign result_kind   = kind_reg;
    assign result_slot   = slot_reg;
    assign victim_key    = vkey_reg;
    assign victim_block  = vblk_reg;
    assign victim_length = vlen_reg;
    assign last          = last_reg;

endmodule

>>> hdl/lwbc_checker.sv
// ----------------------------------------------------------------------------
// lwbc_checker: port-level checks of the directory
// Watches transfers and result strobes on the top-level ports.
// ----------------------------------------------------------------------------
module lwbc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        strobe,
    input logic                        last,
    input logic [lwbc_pkg::KIND_W-1:0] result_kind,
    input logic [lwbc_pkg::LEN_W-1:0]  victim_length
);

    // An accepted item either starts a scan or answers on the next cycle
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || strobe))
        else $error("accepted item neither scanning nor answered");

    // Intermediate results only come out during a scan
    a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
        else $error("non-final result outside a scan");

    // End of a scan delivers the final result
    a_scan_end_final: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && last))
        else $error("scan ended without a final result");

    // Victim length is zero unless a write-back is asked for
    a_len_only_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (result_kind != lwbc_pkg::KIND_WB)) |-> (victim_length == '0))
        else $error("victim length on a non write-back result");

endmodule

bind lru_writeback_block_cache_directory lwbc_checker u_lwbc_checker (.*);
